// ----- rtl/ffea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit extent allocator package
// Shared codes, defaults and the control group that drives every cell.
// ----------------------------------------------------------------------------
package ffea_pkg;

    localparam int MAX_EXTENTS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 38;

    typedef enum logic
    {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic
    {
        CFG_POOL_BASE = 1'b0,
        CFG_POOL_SIZE = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic load;
        logic alloc;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- rtl/ffea_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent cell
// Holds one free extent, checks it against the request and takes part in
// the first-fit priority chain and the shift-insert on free.
// ----------------------------------------------------------------------------
module ffea_cell #(
    parameter int   ADDR_BITS = ffea_pkg::ADDR_BITS_DEF,
    parameter logic HEAD      = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffea_pkg::cell_ctrl_t  ctrl,
    input  logic [ADDR_BITS-1:0]  load_base,
    input  logic [ADDR_BITS:0]    load_len,
    input  logic [ADDR_BITS:0]    req_size,
    input  logic                  prev_valid,
    input  logic [ADDR_BITS-1:0]  prev_base,
    input  logic [ADDR_BITS:0]    prev_len,
    input  logic                  hit_in,
    input  logic [ADDR_BITS-1:0]  addr_in,
    output logic                  valid,
    output logic [ADDR_BITS-1:0]  base,
    output logic [ADDR_BITS:0]    len,
    output logic                  hit_out,
    output logic [ADDR_BITS-1:0]  addr_out
);

    localparam logic [ADDR_BITS:0] RST_LEN = HEAD ? {1'b1, {ADDR_BITS{1'b0}}} : '0;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] base_next;
    logic [ADDR_BITS:0]   len_reg;
    logic [ADDR_BITS:0]   len_next;
    logic                 fit;
    logic                 take;
    logic [ADDR_BITS:0]   rest;
    logic [ADDR_BITS-1:0] carve_addr;

    always_comb
    begin
        fit        = valid_reg && (len_reg >= req_size);
        take       = fit && !hit_in;
        rest       = len_reg - req_size;
        carve_addr = base_reg + rest[ADDR_BITS-1:0];
        hit_out    = hit_in | fit;
        addr_out   = take ? carve_addr : addr_in;
    end

    always_comb
    begin
        valid_next = valid_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        priority if (ctrl.load)
        begin
            valid_next = HEAD;
            base_next  = load_base;
            len_next   = load_len;
        end
        else if (ctrl.shift)
        begin
            valid_next = prev_valid;
            base_next  = prev_base;
            len_next   = prev_len;
        end
        else if (ctrl.alloc && take)
        begin
            len_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= HEAD;
            base_reg  <= '0;
            len_reg   <= RST_LEN;
        end
        else
        begin
            valid_reg <= valid_next;
            base_reg  <= base_next;
            len_reg   <= len_next;
        end
    end

    assign valid = valid_reg;
    assign base  = base_reg;
    assign len   = len_reg;

endmodule

// ----- rtl/first_fit_extent_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit extent allocator core
// Ordered table of free extents held in a row of cells, with first-fit
// allocation from the top of an extent and insert-at-front on free.
// ----------------------------------------------------------------------------
// The block takes one item per clock and presents its result in the output
// register on the following cycle; a new item is taken whenever that register
// is empty or is being read in the same cycle. Each item is resolved in the
// cycle it is accepted, by a priority chain that ripples through all
// MAX_EXTENTS cells, so the length of that chain sets the clock period. Writing
// either pool register reloads the table as the single pool extent.
module first_fit_extent_allocator_core #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF,
    parameter int ADDR_BITS   = ffea_pkg::ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [ADDR_BITS:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [ADDR_BITS-1:0] region_addr,
    input  logic [ADDR_BITS:0]   region_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_BITS-1:0] granted_addr,
    output logic [1:0]           status
);

    logic                 cfg_fire;
    logic                 in_fire;
    logic                 full;
    ffea_pkg::cell_ctrl_t ctrl;

    logic [ADDR_BITS-1:0] pool_base_reg;
    logic [ADDR_BITS-1:0] pool_base_next;
    logic [ADDR_BITS:0]   pool_size_reg;
    logic [ADDR_BITS:0]   pool_size_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ADDR_BITS-1:0] granted_reg;
    logic [ADDR_BITS-1:0] granted_next;
    ffea_pkg::status_t    status_reg;
    ffea_pkg::status_t    status_next;

    logic                 cell_valid [MAX_EXTENTS];
    logic [ADDR_BITS-1:0] cell_base  [MAX_EXTENTS];
    logic [ADDR_BITS:0]   cell_len   [MAX_EXTENTS];
    logic                 hit        [MAX_EXTENTS+1];
    logic [ADDR_BITS-1:0] addr       [MAX_EXTENTS+1];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign full      = cell_valid[MAX_EXTENTS-1];

    always_comb
    begin
        pool_base_next = pool_base_reg;
        pool_size_next = pool_size_reg;
        if (cfg_fire)
        begin
            unique case (ffea_pkg::cfg_index_t'(cfg_index))
                ffea_pkg::CFG_POOL_BASE: pool_base_next = cfg_data[ADDR_BITS-1:0];
                ffea_pkg::CFG_POOL_SIZE: pool_size_next = cfg_data;
                default:                 pool_base_next = pool_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            pool_size_reg <= {1'b1, {ADDR_BITS{1'b0}}};
        end
        else
        begin
            pool_base_reg <= pool_base_next;
            pool_size_reg <= pool_size_next;
        end
    end

    always_comb
    begin
        ctrl.load  = cfg_fire;
        ctrl.alloc = in_fire && (ffea_pkg::action_t'(action) == ffea_pkg::ACT_ALLOC);
        ctrl.shift = in_fire && (ffea_pkg::action_t'(action) == ffea_pkg::ACT_FREE) && !full;
    end

    assign hit[0]  = 1'b0;
    assign addr[0] = '0;

    for (genvar i = 0; i < MAX_EXTENTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            ffea_cell #(
                .ADDR_BITS (ADDR_BITS),
                .HEAD      (1'b1)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .load_base  (pool_base_next),
                .load_len   (pool_size_next),
                .req_size   (region_size),
                .prev_valid (1'b1),
                .prev_base  (region_addr),
                .prev_len   (region_size),
                .hit_in     (hit[i]),
                .addr_in    (addr[i]),
                .valid      (cell_valid[i]),
                .base       (cell_base[i]),
                .len        (cell_len[i]),
                .hit_out    (hit[i+1]),
                .addr_out   (addr[i+1])
            );
        end
        else
        begin : g_body
            ffea_cell #(
                .ADDR_BITS (ADDR_BITS),
                .HEAD      (1'b0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .load_base  (pool_base_next),
                .load_len   (pool_size_next),
                .req_size   (region_size),
                .prev_valid (cell_valid[i-1]),
                .prev_base  (cell_base[i-1]),
                .prev_len   (cell_len[i-1]),
                .hit_in     (hit[i]),
                .addr_in    (addr[i]),
                .valid      (cell_valid[i]),
                .base       (cell_base[i]),
                .len        (cell_len[i]),
                .hit_out    (hit[i+1]),
                .addr_out   (addr[i+1])
            );
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            unique case (ffea_pkg::action_t'(action))
                ffea_pkg::ACT_ALLOC:
                begin
                    granted_next = hit[MAX_EXTENTS] ? addr[MAX_EXTENTS] : '0;
                    status_next  = hit[MAX_EXTENTS] ? ffea_pkg::ST_OK : ffea_pkg::ST_NO_FIT;
                end
                ffea_pkg::ACT_FREE:
                begin
                    granted_next = '0;
                    status_next  = full ? ffea_pkg::ST_FULL : ffea_pkg::ST_OK;
                end
                default:
                begin
                    granted_next = '0;
                    status_next  = ffea_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            granted_reg   <= '0;
            status_reg    <= ffea_pkg::ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            granted_reg   <= granted_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_addr = granted_reg;
    assign status       = status_reg;

`ifndef ASSERT_OFF
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0])
        else $error("The head cell must always hold an extent.");

    a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ffea_pkg::ST_NO_FIT) |-> (granted_addr == '0))
        else $error("A failed allocation must report a zero address.");

    a_reload_single: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire && !in_fire |=> (!cell_valid[1] && cell_valid[0]))
        else $error("A pool reload must leave exactly one extent.");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && full && !cfg_fire |=> full)
        else $error("A full table must stay full until reloaded.");

    a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (ffea_pkg::action_t'(action) == ffea_pkg::ACT_FREE) && !full
        |=> (status == ffea_pkg::ST_OK))
        else $error("A free into a table with room must report success.");
`endif

endmodule

// ----- tb/tb_first_fit_extent_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit extent allocator core testbench
// Drives allocate and free requests through the valid/ready request channel and
// checks each granted address and status against a predictor of the extent
// table. A directed table covers the extremes, the wrap of the granted address,
// zero-size requests and a full table. Random requests then run under several
// pool settings and three patterns of idling on the request and grant sides.
// ----------------------------------------------------------------------------
module tb_first_fit_extent_allocator_core;

    localparam int AW         = ffea_pkg::ADDR_BITS_DEF;
    localparam int NEXT       = ffea_pkg::MAX_EXTENTS_DEF;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASES     = 9;
    localparam int PHASE_REQS = 75;

    typedef struct
    {
        logic [AW-1:0]     addr;
        ffea_pkg::status_t st;
    } grant_t;

    typedef struct
    {
        ffea_pkg::action_t act;
        logic [AW-1:0]     addr;
        logic [AW:0]       size;
        bit                typed;
        logic [AW-1:0]     exp_addr;
        ffea_pkg::status_t exp_st;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [AW:0]   cfg_data;
    logic          in_valid;
    logic          in_ready;
    logic          action;
    logic [AW-1:0] region_addr;
    logic [AW:0]   region_size;
    logic          out_valid;
    logic          out_ready;
    logic [AW-1:0] granted_addr;
    logic [1:0]    status;

    first_fit_extent_allocator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .region_addr  (region_addr),
        .region_size  (region_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_addr (granted_addr),
        .status       (status)
    );

    logic [AW-1:0] pool_base_q;
    logic [AW:0]   pool_size_q;
    logic [AW-1:0] ext_base [NEXT];
    logic [AW:0]   ext_len [NEXT];
    int            ext_count;

    grant_t        pending_grants [$];
    dir_row_t      dir_rows [$];
    grant_t        next_grant;
    grant_t        got_grant;
    bit            row_typed;
    grant_t        row_grant;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            mismatches;
    int            cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void load_pool_extent();
        for (int i = 0; i < NEXT; i++)
        begin
            ext_base[i] = '0;
            ext_len[i]  = '0;
        end
        ext_base[0] = pool_base_q;
        ext_len[0]  = pool_size_q;
        ext_count   = 1;
    endfunction

    function automatic void apply_request(input ffea_pkg::action_t a,
                                          input logic [AW-1:0] ad,
                                          input logic [AW:0] sz, output grant_t g);
        logic [AW:0] rest;
        bit          found;
        g.addr = '0;
        g.st   = ffea_pkg::ST_NO_FIT;
        found  = 1'b0;
        if (a == ffea_pkg::ACT_ALLOC)
        begin
            for (int i = 0; i < ext_count; i++)
            begin
                if (!found && ext_len[i] >= sz)
                begin
                    rest        = ext_len[i] - sz;
                    g.addr      = ext_base[i] + rest[AW-1:0];
                    ext_len[i]  = rest;
                    g.st        = ffea_pkg::ST_OK;
                    found       = 1'b1;
                end
            end
        end
        else if (ext_count >= NEXT)
        begin
            g.st = ffea_pkg::ST_FULL;
        end
        else
        begin
            for (int i = ext_count; i > 0; i--)
            begin
                ext_base[i] = ext_base[i-1];
                ext_len[i]  = ext_len[i-1];
            end
            ext_base[0] = ad;
            ext_len[0]  = sz;
            ext_count++;
            g.st = ffea_pkg::ST_OK;
        end
    endfunction

    function automatic void add_row(input ffea_pkg::action_t a, input logic [AW-1:0] ad,
                                    input logic [AW:0] sz, input bit typed,
                                    input logic [AW-1:0] ea, input ffea_pkg::status_t es);
        dir_row_t r;
        r.act      = a;
        r.addr     = ad;
        r.size     = sz;
        r.typed    = typed;
        r.exp_addr = ea;
        r.exp_st   = es;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic logic [AW:0] pick_alloc_size();
        int unsigned sel;
        int          k;
        logic [AW:0] len;
        sel = $urandom_range(99);
        k   = $urandom_range(ext_count - 1);
        len = ext_len[k];
        if (sel < 5)
            return '0;
        else if (sel < 30)
            return len;
        else if (sel < 40)
            return len + 1'b1;
        else if (sel < 70)
            return (AW+1)'($urandom_range(4096));
        else if (sel < 90)
            return (len == 0) ? '0 : (AW+1)'(rand64() % ({25'd0, len} + 64'd1));
        else
            return (AW+1)'(rand64());
    endfunction

    function automatic logic [AW:0] pick_free_size();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return (AW+1)'($urandom_range(4096));
        else if (sel < 80)
            return (pool_size_q == 0) ? '0
                                      : (AW+1)'(rand64() % ({25'd0, pool_size_q} + 64'd1));
        else
            return (AW+1)'(rand64());
    endfunction

    // Checker and predictor, sampled on the rising edge.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected grant, expected none, actual addr %h status %0d",
                             $time, granted_addr, status);
                    mismatches++;
                end
                else
                begin
                    got_grant = pending_grants.pop_front();
                    if (granted_addr !== got_grant.addr)
                    begin
                        $display("%0t: granted_addr mismatch expected %h actual %h", $time,
                                 got_grant.addr, granted_addr);
                        mismatches++;
                    end
                    if (status !== got_grant.st)
                    begin
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 got_grant.st, status);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                apply_request(ffea_pkg::action_t'(action), region_addr, region_size,
                              next_grant);
                if (row_typed)
                    pending_grants.insert(pending_grants.size(), row_grant);
                else
                    pending_grants.insert(pending_grants.size(), next_grant);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ffea_pkg::CFG_POOL_BASE)
                    pool_base_q = cfg_data[AW-1:0];
                else
                    pool_size_q = cfg_data;
                load_pool_extent();
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input ffea_pkg::action_t a, input logic [AW-1:0] ad,
                             input logic [AW:0] sz, input bit typed,
                             input logic [AW-1:0] ea, input ffea_pkg::status_t es);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed      = typed;
        row_grant.addr = ea;
        row_grant.st   = es;
        in_valid    <= 1'b1;
        action      <= a;
        region_addr <= ad;
        region_size <= sz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input ffea_pkg::cfg_index_t idx, input logic [AW:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure_pool(input int k);
        logic [AW-1:0] b;
        logic [AW:0]   s;
        case (k)
            0:
            begin
                b = '0;
                s = '0;
            end
            1:
            begin
                b = '1;
                s = '1;
            end
            2:
            begin
                b = '1;
                s = {1'b1, {AW{1'b0}}};
            end
            default:
            begin
                b = AW'(rand64());
                s = $urandom_range(1) ? (AW+1)'(rand64()) : (AW+1)'($urandom_range(1 << 20));
            end
        endcase
        if ($urandom_range(1))
        begin
            write_cfg(ffea_pkg::CFG_POOL_BASE, {1'($urandom), b});
            write_cfg(ffea_pkg::CFG_POOL_SIZE, s);
        end
        else
        begin
            write_cfg(ffea_pkg::CFG_POOL_SIZE, s);
            write_cfg(ffea_pkg::CFG_POOL_BASE, {1'($urandom), b});
        end
    endtask

    task automatic run_random(input int n);
        ffea_pkg::action_t a;
        logic [AW-1:0]     ad;
        logic [AW:0]       sz;
        for (int i = 0; i < n; i++)
        begin
            ad = AW'(rand64());
            if ($urandom_range(99) < 30)
            begin
                a  = ffea_pkg::ACT_FREE;
                sz = pick_free_size();
            end
            else
            begin
                a  = ffea_pkg::ACT_ALLOC;
                sz = pick_alloc_size();
            end
            send_item(a, ad, sz, 1'b0, '0, ffea_pkg::ST_OK);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        dir_row_t r;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = ffea_pkg::CFG_POOL_BASE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = ffea_pkg::ACT_ALLOC;
        region_addr    = '0;
        region_size    = '0;
        out_ready      = 1'b0;
        row_typed      = 1'b0;
        row_grant.addr = '0;
        row_grant.st   = ffea_pkg::ST_OK;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 18;
        recv_stall_pct = 73;
        pool_base_q    = '0;
        pool_size_q    = {1'b1, {AW{1'b0}}};
        load_pool_extent();

        // After reset the pool is one extent of 2^38 bytes at address zero.
        add_row(ffea_pkg::ACT_ALLOC, '0, '0, 1'b1, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '0, {1'b1, {(AW-1){1'b0}}, 1'b1}, 1'b1, '0,
                ffea_pkg::ST_NO_FIT);
        add_row(ffea_pkg::ACT_ALLOC, '0, (AW+1)'(1), 1'b1, '1, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '0, {1'b0, {AW{1'b1}}}, 1'b1, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '0, (AW+1)'(1), 1'b1, '0, ffea_pkg::ST_NO_FIT);
        add_row(ffea_pkg::ACT_ALLOC, '0, '0, 1'b1, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_FREE, '1, '1, 1'b1, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '1, (AW+1)'(5), 1'b0, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '0, '1, 1'b1, '0, ffea_pkg::ST_NO_FIT);
        add_row(ffea_pkg::ACT_FREE, '0, '0, 1'b1, '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_ALLOC, '0, '0, 1'b1, '0, ffea_pkg::ST_OK);
        for (int i = 0; i < 13; i++)
            add_row(ffea_pkg::ACT_FREE, AW'(i * 'h1000 + 'h100), (AW+1)'('h40 + i), 1'b1,
                    '0, ffea_pkg::ST_OK);
        add_row(ffea_pkg::ACT_FREE, AW'('h123), (AW+1)'('h10), 1'b1, '0,
                ffea_pkg::ST_FULL);
        add_row(ffea_pkg::ACT_ALLOC, '0, (AW+1)'('h45), 1'b0, '0, ffea_pkg::ST_OK);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            send_item(r.act, r.addr, r.size, r.typed, r.exp_addr, r.exp_st);
        end
        in_valid <= 1'b0;

        for (int k = 0; k < PHASES; k++)
        begin
            case (k / 3)
                0:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 73;
                end
                1:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 18;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            wait_drain();
            configure_pool(k);
            run_random(PHASE_REQS);
        end

        wait_drain();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
